// ===== design/utf8d_pkg.sv =====
package utf8d_pkg;

    localparam int unsigned UnitW = 21;

    localparam logic [UnitW-1:0] BadChar     = 21'h00003F;
    localparam logic [UnitW-1:0] PlaneOne    = 21'h010000;
    localparam logic [UnitW-1:0] Mask16      = 21'h00FFFF;
    localparam logic [UnitW-1:0] HighSurBase = 21'h00D800;
    localparam logic [UnitW-1:0] LowSurBase  = 21'h00DC00;

    localparam logic [1:0] SeqTwo   = 2'd1;
    localparam logic [1:0] SeqThree = 2'd2;
    localparam logic [1:0] SeqFour  = 2'd3;

    typedef struct packed {
        logic             skipping;
        logic [1:0]       remaining;
        logic [1:0]       seq_length;
        logic [UnitW-1:0] accum;
    } dec_state_t;

    typedef struct packed {
        logic [1:0]       count;
        logic [UnitW-1:0] unit0;
        logic             last0;
        logic [UnitW-1:0] unit1;
    } dec_result_t;

endpackage

// ===== design/utf8d_decode.sv =====
module utf8d_decode
    import utf8d_pkg::*;
(
    input  logic [7:0]  in_byte,
    input  dec_state_t  state,
    input  logic        unit_mode,
    output dec_state_t  state_next,
    output dec_result_t result
);

    logic             cont;
    logic             do_lead;
    logic [UnitW-1:0] acc_ext;
    logic [UnitW-1:0] ch;
    logic [UnitW-1:0] v;
    logic [UnitW-1:0] mask;

    assign cont    = (in_byte[7:6] == 2'b10);
    assign acc_ext = {state.accum[UnitW-7:0], in_byte[5:0]};
    assign mask    = unit_mode ? {UnitW{1'b1}} : Mask16;

    // surrogate range check and replacement on the completed code point
    always_comb
    begin
        ch = acc_ext;
        if (state.seq_length == SeqThree && acc_ext[15:11] == 5'b11011)
        begin
            ch = BadChar;
        end
        else if (state.seq_length == SeqFour && acc_ext[20:11] == 10'b0000011011)
        begin
            ch = BadChar;
        end
    end

    assign v = ch - PlaneOne;

    always_comb
    begin
        state_next   = state;
        result       = '0;
        result.last0 = 1'b1;
        do_lead      = 1'b0;

        if (state.remaining != 2'd0)
        begin
            if (cont)
            begin
                state_next.accum     = acc_ext;
                state_next.remaining = state.remaining - 2'd1;
                if (state.remaining == 2'd1)
                begin
                    if (state.seq_length == SeqFour && ch >= PlaneOne && !unit_mode)
                    begin
                        result.count = 2'd2;
                        result.unit0 = ({10'd0, v[UnitW-1:10]} | HighSurBase) & mask;
                        result.last0 = 1'b0;
                        result.unit1 = ({11'd0, v[9:0]} | LowSurBase) & mask;
                    end
                    else
                    begin
                        result.count = 2'd1;
                        result.unit0 = ch & mask;
                    end
                end
            end
            else
            begin
                // broken sequence: drop it and treat this byte as a lead
                state_next.remaining = 2'd0;
                state_next.accum     = '0;
                do_lead              = 1'b1;
            end
        end
        else if (state.skipping)
        begin
            if (!cont)
            begin
                state_next.skipping = 1'b0;
                do_lead             = 1'b1;
            end
        end
        else
        begin
            do_lead = 1'b1;
        end

        if (do_lead)
        begin
            case (in_byte) inside
                8'h00:
                begin
                    state_next = '0;
                end
                [8'h01:8'h7F]:
                begin
                    result.count = 2'd1;
                    result.unit0 = {13'd0, in_byte};
                end
                [8'hC0:8'hDF]:
                begin
                    state_next.accum      = {16'd0, in_byte[4:0]};
                    state_next.seq_length = SeqTwo;
                    state_next.remaining  = SeqTwo;
                end
                [8'hE0:8'hEF]:
                begin
                    state_next.accum      = {17'd0, in_byte[3:0]};
                    state_next.seq_length = SeqThree;
                    state_next.remaining  = SeqThree;
                end
                [8'hF0:8'hF7]:
                begin
                    state_next.accum      = {18'd0, in_byte[2:0]};
                    state_next.seq_length = SeqFour;
                    state_next.remaining  = SeqFour;
                end
                default:
                begin
                    // stray continuation or invalid lead
                    state_next.skipping = 1'b1;
                end
            endcase
        end
    end

endmodule

// ===== design/utf8_to_wide_decoder.sv =====
// utf8_to_wide_decoder: streaming utf-8 to utf-16 / utf-32 decoder.
// input channel: one utf-8 byte per beat on in_byte (in_valid / in_stall).
// output channel: one code unit per beat on code_unit, with last_unit set on
// the final unit that a byte produced (out_valid / out_stall).
// cfg_write with cfg_data selects the unit width: 0 gives 16-bit units with
// surrogate pairs, 1 gives full 21-bit code points. write it only when idle.
// an accepted byte is held in the input register, is decoded in a
// single pass and lands in the result register. one byte per cycle is
// taken while the output flows; a surrogate pair holds the decoder while
// the low half leaves through the pending register. bytes that give no
// unit pass the decoder even while the output is stalled.
// when the receiver stalls, results wait in the result register and the
// input register fills, then in_stall rises.
// reset clears the partial sequence, the skip flag, the unit mode and all
// valid flags; a zero byte also clears the decoder state.
module utf8_to_wide_decoder
    import utf8d_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic             cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       in_byte,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [UnitW-1:0] code_unit,
    output logic             last_unit
);

    logic             unit_mode_reg;
    logic             byte_valid_reg;
    logic [7:0]       byte_reg;
    dec_state_t       state_reg;
    dec_state_t       state_next;
    dec_result_t      result;
    logic             out_valid_reg;
    logic [UnitW-1:0] unit_reg;
    logic             last_reg;
    logic             pend_valid_reg;
    logic [UnitW-1:0] pend_reg;
    logic             out_free;
    logic             consume;
    logic             in_take;

    utf8d_decode u_decode (
        .in_byte    (byte_reg),
        .state      (state_reg),
        .unit_mode  (unit_mode_reg),
        .state_next (state_next),
        .result     (result)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign consume  = byte_valid_reg
                      && (result.count == 2'd0 || (!pend_valid_reg && out_free));
    assign in_stall = byte_valid_reg && !consume;
    assign in_take  = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign code_unit = unit_reg;
    assign last_unit = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_mode_reg  <= 1'b0;
            byte_valid_reg <= 1'b0;
            state_reg      <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unit_mode_reg <= cfg_data;
            end

            if (in_take)
            begin
                byte_valid_reg <= 1'b1;
            end
            else if (consume)
            begin
                byte_valid_reg <= 1'b0;
            end

            if (consume)
            begin
                state_reg <= state_next;
            end

            if (consume && result.count != 2'd0)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= (result.count == 2'd2);
            end
            else if (pend_valid_reg && out_free)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= in_byte;
        end

        if (consume && result.count != 2'd0)
        begin
            unit_reg <= result.unit0;
            last_reg <= result.last0;
            pend_reg <= result.unit1;
        end
        else if (pend_valid_reg && out_free)
        begin
            // low surrogate follows its high half
            unit_reg <= pend_reg;
            last_reg <= 1'b1;
        end
    end

endmodule

// ===== tb/sv/tb_utf8_to_wide_decoder.sv =====
`timescale 1ns / 100ps

module tb_utf8_to_wide_decoder
    import utf8d_pkg::*;
();

    localparam int NumPhases    = 5;
    localparam int RandomPerPhase = 340;
    localparam int QuietLimit   = 2000;
    localparam int DrainCycles  = 8;
    localparam int MaxPrinted   = 20;

    localparam logic [7:0] LeadTwo   = 8'hC0;
    localparam logic [7:0] LeadThree = 8'hE0;
    localparam logic [7:0] LeadFour  = 8'hF0;
    localparam logic [7:0] LeadBad   = 8'hF8;

    localparam logic [7:0] DirectedBytes [26] = '{
        8'h00, 8'h7F,
        8'hC0, 8'h80,                 // overlong zero
        8'hDF, 8'hBF,                 // top of the 2-byte range
        8'hED, 8'hA0, 8'h80,          // surrogate value gives '?'
        8'hF0, 8'h9F, 8'h98, 8'h80,   // plane one, pair in 16-bit mode
        8'hF7, 8'hBF, 8'hBF, 8'hBF,   // largest 4-byte value
        8'hE2, 8'h82, 8'h41,          // sequence broken by ascii
        8'h80, 8'hBF, 8'hFF, 8'h41,   // stray continuation, invalid lead
        8'hF8, 8'h00                  // zero ends a skip
    };

    localparam int PhaseMode [NumPhases]      = '{0, 1, 0, 1, 0};
    localparam int PhaseSendIdle [NumPhases]  = '{0, 56, 0, 30, 0};
    localparam int PhaseRecvStall [NumPhases] = '{0, 0, 56, 30, 0};

    typedef struct {
        logic [UnitW-1:0] unit;
        logic             last;
    } unit_beat_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_write = 1'b0;
    logic             cfg_data  = 1'b0;
    logic             in_valid  = 1'b0;
    logic [7:0]       in_byte   = 8'h00;
    logic             out_stall = 1'b0;
    logic             in_stall;
    logic             out_valid;
    logic [UnitW-1:0] code_unit;
    logic             last_unit;

    // decoder state as the block should hold it
    logic             dec_mode      = 1'b0;
    logic [1:0]       dec_remaining = 2'd0;
    logic [1:0]       dec_len       = 2'd0;
    logic [UnitW-1:0] dec_accum     = '0;
    logic             dec_skip      = 1'b0;

    logic [7:0] pending_bytes [$];
    unit_beat_t expected_units [$];
    unit_beat_t want_unit;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int bytes_queued   = 0;
    int bytes_taken    = 0;
    int units_checked  = 0;
    int pairs_seen     = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;

    utf8_to_wide_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .code_unit (code_unit),
        .last_unit (last_unit)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MaxPrinted)
            $display("mismatch %s: got %h want %h after %0d bytes", what, got, want,
                     bytes_taken);
    endtask

    task automatic push_unit(input logic [UnitW-1:0] u, input logic last);
        unit_beat_t e;
        e.unit = dec_mode ? u : (u & Mask16);
        e.last = last;
        expected_units.push_back(e);
    endtask

    task automatic complete_sequence();
        logic [UnitW-1:0] cp;
        logic [UnitW-1:0] v;
        cp = dec_accum;
        if (dec_len != SeqTwo && cp >= HighSurBase && cp < HighSurBase + 21'h000800)
            cp = BadChar;
        if (dec_len == SeqFour && cp >= PlaneOne && !dec_mode)
        begin
            v = cp - PlaneOne;
            push_unit((v >> 10) | HighSurBase, 1'b0);
            push_unit((v & 21'h0003FF) | LowSurBase, 1'b1);
            pairs_seen++;
        end
        else
            push_unit(cp, 1'b1);
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic is_cont;
        logic as_lead;
        is_cont = (b[7:6] == 2'b10);
        as_lead = 1'b1;
        if (dec_remaining != 2'd0)
        begin
            if (is_cont)
            begin
                dec_accum = {dec_accum[UnitW-7:0], b[5:0]};
                dec_remaining = dec_remaining - 2'd1;
                if (dec_remaining == 2'd0)
                    complete_sequence();
                as_lead = 1'b0;
            end
            else
            begin
                dec_remaining = 2'd0;
                dec_accum = '0;
            end
        end
        else if (dec_skip)
        begin
            if (is_cont)
                as_lead = 1'b0;
            else
                dec_skip = 1'b0;
        end
        if (as_lead)
        begin
            if (b == 8'h00)
            begin
                dec_remaining = 2'd0;
                dec_len = 2'd0;
                dec_accum = '0;
                dec_skip = 1'b0;
            end
            else if (b < 8'h80)
                push_unit({13'd0, b}, 1'b1);
            else if (b < LeadTwo || b >= LeadBad)
                dec_skip = 1'b1;
            else
            begin
                if (b < LeadThree)
                begin
                    dec_accum = {16'd0, b[4:0]};
                    dec_len = SeqTwo;
                end
                else if (b < LeadFour)
                begin
                    dec_accum = {17'd0, b[3:0]};
                    dec_len = SeqThree;
                end
                else
                begin
                    dec_accum = {18'd0, b[2:0]};
                    dec_len = SeqFour;
                end
                dec_remaining = dec_len;
            end
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        bytes_queued++;
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // mostly well-formed sequences, the rest broken ones and noise
    task automatic add_random_chunk();
        int kind;
        int len;
        int n;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        len = (kind < 70) ? $urandom_range(1, 4) : $urandom_range(2, 4);
        case (len)
            1: b = 8'($urandom_range(1, 127));
            2: b = LeadTwo | 8'($urandom_range(0, 31));
            3: b = LeadThree | 8'($urandom_range(0, 15));
            default: b = LeadFour | 8'($urandom_range(0, 7));
        endcase
        if (kind < 6)
        begin
            push_byte(8'hED);
            push_byte(8'hA0 | 8'($urandom_range(0, 31)));
            push_byte(cont_byte());
        end
        else if (kind < 70)
        begin
            push_byte(b);
            for (n = 1; n < len; n++)
                push_byte(cont_byte());
        end
        else if (kind < 80)
        begin
            push_byte(b);
            n = $urandom_range(0, len - 2);
            repeat (n) push_byte(cont_byte());
            b = 8'($urandom_range(0, 255));
            if (b[7:6] == 2'b10)
                b[6] = 1'b1;
            push_byte(b);
        end
        else if (kind < 90)
        begin
            if ($urandom_range(0, 1))
                push_byte(cont_byte());
            else
                push_byte(LeadBad | 8'($urandom_range(0, 7)));
            n = $urandom_range(0, 3);
            repeat (n) push_byte(cont_byte());
        end
        else if (kind < 94)
        begin
            push_byte(b);
            n = $urandom_range(0, len - 2);
            repeat (n) push_byte(cont_byte());
            push_byte(8'h00);
        end
        else
            push_byte(8'($urandom_range(0, 255)));
    endtask

    // sender: a stalled beat holds, otherwise the next byte or a gap
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
            begin
                decode_byte(in_byte);
                bytes_taken++;
            end
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_byte  <= pending_bytes.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                units_checked++;
                if (expected_units.size() == 0)
                    report_mismatch("unit with nothing expected", 32'(code_unit), 32'd0);
                else
                begin
                    want_unit = expected_units.pop_front();
                    if (code_unit !== want_unit.unit)
                        report_mismatch("code_unit", 32'(code_unit), 32'(want_unit.unit));
                    if (last_unit !== want_unit.last)
                        report_mismatch("last_unit", 32'(last_unit), 32'(want_unit.last));
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QuietLimit)
            begin
                $display("timeout: no beat for %0d cycles", quiet_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || in_valid || expected_units.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    initial
    begin
        int p;
        int target;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        for (p = 0; p < NumPhases; p++)
        begin
            @(posedge clk);
            cfg_write <= 1'b1;
            cfg_data  <= PhaseMode[p][0];
            @(posedge clk);
            cfg_write <= 1'b0;
            dec_mode = PhaseMode[p][0];
            @(negedge clk);
            send_idle_pct  = PhaseSendIdle[p];
            recv_stall_pct = PhaseRecvStall[p];
            if (p == 0)
                foreach (DirectedBytes[i])
                    push_byte(DirectedBytes[i]);
            target = bytes_queued + RandomPerPhase;
            while (bytes_queued < target)
                add_random_chunk();
            wait_drained();
        end
        if (expected_units.size() != 0)
            report_mismatch("units still expected", expected_units.size(), 32'd0);
        $display("%0d bytes over %0d phases in both unit widths, %0d units checked",
                 bytes_taken, NumPhases, units_checked);
        $display("%0d surrogate pairs, %0d mismatches", pairs_seen, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
design/utf8d_pkg.sv
design/utf8d_decode.sv
design/utf8_to_wide_decoder.sv
tb/sv/tb_utf8_to_wide_decoder.sv
